@@ hw/rtl/afr_pkg.sv @@
package afr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;

  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Framing constants
  localparam byte_t START_BYTE = 8'h7E;
  localparam byte_t SUM_BASE   = 8'hFF;

  // Result status codes
  localparam status_t ST_PAYLOAD = 2'd0;
  localparam status_t ST_BAD_SUM = 2'd1;
  localparam status_t ST_BAD_LEN = 2'd2;

endpackage

@@ hw/rtl/afr_if.sv @@
interface afr_in_if import afr_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface afr_out_if import afr_pkg::*; ();
  logic    valid;
  logic    ready;
  byte_t   payload_byte;
  logic    last_byte;
  status_t frame_status;

  modport source (output valid, output payload_byte, output last_byte,
                  output frame_status, input ready);
  modport sink (input valid, input payload_byte, input last_byte,
                input frame_status, output ready);
endinterface

@@ hw/rtl/afr_ram.sv @@
module afr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/api_frame_receiver.sv @@
// Receive-side deframer for API frames. Each input item is one byte from the
// serial link: the block hunts for the start byte 0x7E, reads a big-endian
// 16-bit length, stores that many payload bytes in a RAM while summing them,
// and checks the following checksum byte against 0xFF minus the sum. A good
// frame is replayed from the RAM as one result item per payload byte, the
// last one flagged; a bad checksum or a length above MAX_PAYLOAD gives a
// single error item with last_byte set. Bytes are taken one per cycle while
// the output is free and no replay is under way. Replay uses the single read
// port of the payload RAM (one byte per cycle when the sink keeps up), and no
// byte is accepted until the last one has left the RAM read stage.
// The RAM needs no initialisation: only entries of the current frame are read.
module api_frame_receiver import afr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  afr_in_if.sink    rx_i,
  afr_out_if.source res_o
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_LEN_HI = 3'd1;
  localparam logic [2:0] PH_LEN_LO = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_CHECK  = 3'd4;
  localparam logic [2:0] PH_REPLAY = 3'd5;

  logic [2:0]    phase_q, phase_d;
  byte_t         len_hi_q, len_hi_d;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] cnt_q, cnt_d;
  byte_t         sum_q, sum_d;
  logic          pend_q, pend_d;
  logic          pend_last_q, pend_last_d;
  logic          out_valid_q, out_valid_d;
  byte_t         out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;
  status_t       out_status_q, out_status_d;

  logic          acc, out_free, move;
  logic          ram_we, ram_re;
  byte_t         ram_rdata;
  logic [15:0]   length16;
  logic [CW-1:0] cnt_inc;

  afr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (rx_i.rx_byte),
    .re_i    (ram_re),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || res_o.ready;
  assign move     = pend_q && out_free;
  assign rx_i.ready = (phase_q != PH_REPLAY) && !pend_q && out_free;
  assign acc      = rx_i.valid && rx_i.ready;
  assign ram_re   = (phase_q == PH_REPLAY) && (!pend_q || move);
  assign ram_we   = acc && (phase_q == PH_DATA);
  assign length16 = {len_hi_q, rx_i.rx_byte};
  assign cnt_inc  = cnt_q + CW'(1);

  always_comb begin
    phase_d      = phase_q;
    len_hi_d     = len_hi_q;
    len_d        = len_q;
    cnt_d        = cnt_q;
    sum_d        = sum_q;
    pend_d       = pend_q;
    pend_last_d  = pend_last_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;

    // Move the RAM read stage into the output register
    if (move) begin
      pend_d       = 1'b0;
      out_valid_d  = 1'b1;
      out_byte_d   = ram_rdata;
      out_last_d   = pend_last_q;
      out_status_d = ST_PAYLOAD;
    end

    if (ram_re) begin
      pend_d      = 1'b1;
      pend_last_d = (cnt_inc == len_q);
      cnt_d       = cnt_inc;
      if (cnt_inc == len_q) begin
        phase_d = PH_HUNT;
      end
    end

    if (acc) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_i.rx_byte == START_BYTE) begin
            phase_d = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          len_hi_d = rx_i.rx_byte;
          phase_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          sum_d = '0;
          cnt_d = '0;
          if (length16 > 16'(MAX_PAYLOAD)) begin
            out_valid_d  = 1'b1;
            out_byte_d   = '0;
            out_last_d   = 1'b1;
            out_status_d = ST_BAD_LEN;
            phase_d      = PH_HUNT;
          end else begin
            len_d   = length16[CW-1:0];
            phase_d = (length16 == 16'd0) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          sum_d = sum_q + rx_i.rx_byte;
          cnt_d = cnt_inc;
          if (cnt_inc >= len_q) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          cnt_d = '0;
          if (byte_t'(rx_i.rx_byte + sum_q) != SUM_BASE) begin
            out_valid_d  = 1'b1;
            out_byte_d   = '0;
            out_last_d   = 1'b1;
            out_status_d = ST_BAD_SUM;
            phase_d      = PH_HUNT;
          end else if (len_q != '0) begin
            phase_d = PH_REPLAY;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      len_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_hi_q     <= len_hi_d;
    pend_last_q  <= pend_last_d;
    out_byte_q   <= out_byte_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.payload_byte = out_byte_q;
  assign res_o.last_byte    = out_last_q;
  assign res_o.frame_status = out_status_q;

  // A held RAM read must not be lost while the output stalls
  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && out_valid_q && !res_o.ready |=> pend_q)
    else $error("pending RAM read dropped under stall");

  a_we_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (cnt_q < len_q))
    else $error("payload write beyond frame length");

  a_re_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (cnt_q < len_q))
    else $error("replay read beyond frame length");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA || phase_q == PH_REPLAY) |-> (len_q != '0)
      && (len_q <= CW'(MAX_PAYLOAD)))
    else $error("stored frame length out of range");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> out_status_q == ST_PAYLOAD)
    else $error("replayed byte overwritten by an error item");

endmodule
